// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the gesture decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define TBGD_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define TBGD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tbgd_pkg.sv =====
// Types, codes and constants shared by the gesture decoder modules.
package tbgd_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 24;
    localparam int ACT_W   = 3;
    localparam int CMD_W   = 4;
    localparam int IDX_W   = 3;
    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int OUT_DATA_W = ((CMD_W + 7) / 8) * 8;

    // Button masks (bit 0 A, bit 1 B)
    localparam logic [1:0] BTN_A = 2'b01;
    localparam logic [1:0] BTN_B = 2'b10;

    // Time-valid flag positions
    localparam int TV_FIRST = 0;
    localparam int TV_DUAL  = 1;
    localparam int TV_LASTB = 2;

    // Register reset values
    localparam logic [CFG_W-1:0] DPW_RST = CFG_W'(50000);
    localparam logic [CFG_W-1:0] LHM_RST = CFG_W'(1000000);
    localparam logic [CFG_W-1:0] SPM_RST = CFG_W'(300000);
    localparam logic [CFG_W-1:0] DTW_RST = CFG_W'(300000);
    localparam logic             START_MODE_RST = 1'b0;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK    = 3'd0,
        ACT_A_PRESS = 3'd1,
        ACT_A_REL   = 3'd2,
        ACT_B_PRESS = 3'd3,
        ACT_B_REL   = 3'd4
    } act_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_A_PRESS_M0 = 4'd0,
        CMD_A_REL_M0   = 4'd1,
        CMD_B_PRESS_M0 = 4'd2,
        CMD_B_REL_M0   = 4'd3,
        CMD_A_TOGGLE   = 4'd4,
        CMD_B_PRESS_M1 = 4'd5,
        CMD_B_REL_M1   = 4'd6,
        CMD_ARM        = 4'd7,
        CMD_UNARM      = 4'd8,
        CMD_PANIC      = 4'd9,
        CMD_ENTER_M0   = 4'd10,
        CMD_ENTER_M1   = 4'd11
    } cmd_t;

    typedef enum logic [IDX_W-1:0] {
        REG_DPW        = 3'd0,
        REG_LHM        = 3'd1,
        REG_SPM        = 3'd2,
        REG_DTW        = 3'd3,
        REG_START_MODE = 3'd4
    } reg_idx_t;

    // Commands caused by one item
    typedef struct packed {
        logic [CNT_W-1:0]                cnt;
        logic [MAX_RES-1:0][CMD_W-1:0]   cmd;
    } bundle_t;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/two_button_gesture_decoder_top.sv =====
// Top level of the two-button gesture decoder.
// Input channel s_axis: one button event per item; tuser carries the action code
// (tick, A press, A release, B press, B release) and tdata the 32-bit microsecond
// timestamp. Output channel m_axis: one command per item, tlast set on the last
// command that an input item causes; items that cause no command produce nothing.
// Configuration: cfg_we with cfg_index selects one of the window/hold registers or
// the start mode; writing the start mode also sets the current mode. Write only
// while the block is idle.
// An item's commands are written into the bundle queue when it is accepted and are
// offered from its head, one command per cycle while the receiver takes them.
// Throughput: one item per cycle while the two-entry bundle queue between the front
// and back parts has room; a bundle holds the output until its last command is taken.
// When the receiver stalls, the queue fills and s_axis_tready drops; it returns
// the cycle after a bundle's last command is taken.
// Reset clears all gesture state, loads the default windows and mode 0, and
// empties the queue.
module two_button_gesture_decoder_top
    import tbgd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TIME_W-1:0]     s_axis_tdata,   // [31:0] time_us
    input  logic [ACT_W-1:0]      s_axis_tuser,   // [2:0] action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [3:0] command, rest zero
    output logic                  m_axis_tlast
);

    q_stat_t          q_stat;
    logic             push, pop;
    bundle_t          push_bundle, head;
    logic [CMD_W-1:0] out_cmd;

    tbgd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_action   (s_axis_tuser),
        .in_time     (s_axis_tdata),
        .q_stat      (q_stat),
        .push        (push),
        .push_bundle (push_bundle)
    );

    tbgd_queue u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .head        (head),
        .q_stat      (q_stat)
    );

    tbgd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_cmd   (out_cmd),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_DATA_W'(out_cmd);

endmodule

// ===== rtl/tbgd_front.sv =====
// Front part: takes events, updates gesture state and builds command bundles.
module tbgd_front
    import tbgd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ACT_W-1:0]     in_action,
    input  logic [TIME_W-1:0]    in_time,
    input  q_stat_t              q_stat,
    output logic                 push,
    output bundle_t              push_bundle
);

`include "assert_macros.svh"

    // Configuration registers
    logic [CFG_W-1:0] dpw_reg, lhm_reg, spm_reg, dtw_reg;

    // Gesture state
    logic             mode_reg, mode_next;
    logic [1:0]       pressed_reg, pressed_next;
    logic [1:0]       pending_reg, pending_next;
    logic [1:0]       disp_reg, disp_next;
    logic             dual_act_reg, dual_act_next;
    logic             dual_hdl_reg, dual_hdl_next;
    logic             wait_tap_reg, wait_tap_next;
    logic             root_hold_reg, root_hold_next;
    logic [2:0]       tv_reg, tv_next;
    logic [TIME_W-1:0] first_t_reg, first_t_next;
    logic [TIME_W-1:0] dual_t_reg, dual_t_next;
    logic [TIME_W-1:0] lastb_t_reg, lastb_t_next;

    logic [TIME_W-1:0] el_first, el_dual, el_lastb, el_first_press;
    logic              accept;
    logic              is_b;
    logic [1:0]        bm, om;
    bundle_t           bnd;

    // Append one command to a bundle
    function automatic bundle_t add_cmd(bundle_t b, cmd_t c);
        bundle_t r;
        r = b;
        if (r.cnt < CNT_W'(MAX_RES))
        begin
            r.cmd[r.cnt[CNT_W-1:0]] = c;
            r.cnt = r.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // Elapsed times, modulo 2^32
    assign el_first = in_time - first_t_reg;
    assign el_dual  = in_time - dual_t_reg;
    assign el_lastb = in_time - lastb_t_reg;
    // A second press with no first time starts its window now
    assign el_first_press = tv_reg[TV_FIRST] ? el_first : '0;

    assign is_b = (in_action == ACT_B_PRESS) || (in_action == ACT_B_REL);
    assign bm   = is_b ? BTN_B : BTN_A;
    assign om   = bm ^ 2'b11;

    // Step the gesture state for one item
    always_comb
    begin
        mode_next      = mode_reg;
        pressed_next   = pressed_reg;
        pending_next   = pending_reg;
        disp_next      = disp_reg;
        dual_act_next  = dual_act_reg;
        dual_hdl_next  = dual_hdl_reg;
        wait_tap_next  = wait_tap_reg;
        root_hold_next = root_hold_reg;
        tv_next        = tv_reg;
        first_t_next   = first_t_reg;
        dual_t_next    = dual_t_reg;
        lastb_t_next   = lastb_t_reg;
        bnd            = '0;

        unique case (in_action) inside
            ACT_TICK:
            begin
                // Long dual hold toggles the mode
                if (dual_act_reg && !dual_hdl_reg && tv_reg[TV_DUAL] &&
                    (el_dual >= {8'd0, lhm_reg}))
                begin
                    pending_next   = '0;
                    disp_next      = '0;
                    wait_tap_next  = 1'b0;
                    root_hold_next = 1'b0;
                    tv_next[TV_LASTB] = 1'b0;
                    mode_next      = !mode_reg;
                    bnd = add_cmd(bnd, mode_reg ? CMD_ENTER_M0 : CMD_ENTER_M1);
                    dual_hdl_next  = 1'b1;
                end
                // Release held-back single presses once the window has passed
                if (!mode_next && !dual_act_reg && tv_reg[TV_FIRST] &&
                    (el_first >= {8'd0, dpw_reg}))
                begin
                    if (pending_next[0] && !disp_next[0])
                    begin
                        bnd = add_cmd(bnd, CMD_A_PRESS_M0);
                        disp_next[0]    = 1'b1;
                        pending_next[0] = 1'b0;
                    end
                    if (pending_next[1] && !disp_next[1])
                    begin
                        bnd = add_cmd(bnd, CMD_B_PRESS_M0);
                        disp_next[1]    = 1'b1;
                        pending_next[1] = 1'b0;
                    end
                end
            end
            ACT_A_PRESS, ACT_B_PRESS:
            begin
                pressed_next = pressed_reg | bm;
                if ((pressed_next & om) == 2'b00)
                begin
                    // Single press
                    if (mode_reg && !is_b)
                    begin
                        bnd = add_cmd(bnd, CMD_A_TOGGLE);
                        disp_next[0]    = 1'b1;
                        pending_next[0] = 1'b0;
                        first_t_next    = in_time;
                        tv_next[TV_FIRST] = 1'b1;
                    end
                    else if (mode_reg && wait_tap_reg && tv_reg[TV_LASTB] &&
                             (el_lastb <= {8'd0, dtw_reg}))
                    begin
                        // Second tap arms root edit
                        wait_tap_next   = 1'b0;
                        root_hold_next  = 1'b1;
                        bnd = add_cmd(bnd, CMD_ARM);
                        pending_next[1] = 1'b0;
                        disp_next[1]    = 1'b0;
                        first_t_next    = in_time;
                        tv_next[TV_FIRST] = 1'b1;
                    end
                    else
                    begin
                        if (mode_reg)
                        begin
                            root_hold_next = 1'b0;
                            wait_tap_next  = 1'b1;
                            bnd = add_cmd(bnd, CMD_B_PRESS_M1);
                        end
                        first_t_next = in_time;
                        tv_next[TV_FIRST] = 1'b1;
                        pending_next = pending_reg | bm;
                    end
                end
                else
                begin
                    // Other button already down
                    if (!tv_reg[TV_FIRST])
                    begin
                        first_t_next = in_time;
                        tv_next[TV_FIRST] = 1'b1;
                    end
                    if (el_first_press <= {8'd0, dpw_reg})
                    begin
                        if (!dual_act_reg)
                        begin
                            // Revert optimistic single actions
                            if (mode_reg && disp_reg[0])
                            begin
                                bnd = add_cmd(bnd, CMD_A_TOGGLE);
                            end
                            if (mode_reg && pressed_next[1])
                            begin
                                if (root_hold_reg)
                                begin
                                    bnd = add_cmd(bnd, CMD_UNARM);
                                    root_hold_next = 1'b0;
                                end
                                else
                                begin
                                    bnd = add_cmd(bnd, CMD_B_REL_M1);
                                end
                                wait_tap_next = 1'b0;
                            end
                            dual_act_next = 1'b1;
                            dual_hdl_next = 1'b0;
                            dual_t_next   = in_time;
                            tv_next[TV_DUAL] = 1'b1;
                        end
                        pending_next = '0;
                        disp_next    = '0;
                    end
                    else
                    begin
                        pending_next = pending_reg | bm;
                    end
                end
            end
            ACT_A_REL, ACT_B_REL:
            begin
                pressed_next = pressed_reg & om;
                if (!dual_act_reg)
                begin
                    if (mode_reg)
                    begin
                        if (is_b)
                        begin
                            if (root_hold_reg)
                            begin
                                bnd = add_cmd(bnd, CMD_UNARM);
                                root_hold_next = 1'b0;
                                wait_tap_next  = 1'b0;
                            end
                            else
                            begin
                                bnd = add_cmd(bnd, CMD_B_REL_M1);
                                wait_tap_next = !tv_reg[TV_FIRST] ||
                                                (el_first <= {8'd0, spm_reg});
                            end
                            lastb_t_next = in_time;
                            tv_next[TV_LASTB] = 1'b1;
                        end
                        pending_next = pending_reg & om;
                        disp_next    = disp_reg & om;
                    end
                    else
                    begin
                        // Held-back press goes out just before its release
                        if (((pending_reg & bm) != 2'b00) && ((disp_reg & bm) == 2'b00))
                        begin
                            bnd = add_cmd(bnd, is_b ? CMD_B_PRESS_M0 : CMD_A_PRESS_M0);
                            disp_next    = disp_reg | bm;
                            pending_next = pending_reg & om;
                        end
                        if ((disp_next & bm) != 2'b00)
                        begin
                            bnd = add_cmd(bnd, is_b ? CMD_B_REL_M0 : CMD_A_REL_M0);
                            disp_next = disp_next & om;
                        end
                    end
                end
                // Both buttons up: close any dual press
                if (pressed_next == 2'b00)
                begin
                    if (dual_act_reg && !dual_hdl_reg && tv_reg[TV_DUAL] &&
                        (el_dual <= {8'd0, spm_reg}) && !mode_reg)
                    begin
                        bnd = add_cmd(bnd, CMD_PANIC);
                    end
                    dual_act_next  = 1'b0;
                    dual_hdl_next  = 1'b0;
                    tv_next[TV_FIRST] = 1'b0;
                    tv_next[TV_DUAL]  = 1'b0;
                    root_hold_next = 1'b0;
                    pending_next   = '0;
                    disp_next      = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign push        = accept && (bnd.cnt != '0);
    assign push_bundle = bnd;

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpw_reg        <= DPW_RST;
            lhm_reg        <= LHM_RST;
            spm_reg        <= SPM_RST;
            dtw_reg        <= DTW_RST;
            mode_reg       <= START_MODE_RST;
            pressed_reg    <= '0;
            pending_reg    <= '0;
            disp_reg       <= '0;
            dual_act_reg   <= 1'b0;
            dual_hdl_reg   <= 1'b0;
            wait_tap_reg   <= 1'b0;
            root_hold_reg  <= 1'b0;
            tv_reg         <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DPW:        dpw_reg <= cfg_wdata;
                REG_LHM:        lhm_reg <= cfg_wdata;
                REG_SPM:        spm_reg <= cfg_wdata;
                REG_DTW:        dtw_reg <= cfg_wdata;
                REG_START_MODE:
                begin
                    mode_reg       <= cfg_wdata[0];
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            pressed_reg   <= pressed_next;
            pending_reg   <= pending_next;
            disp_reg      <= disp_next;
            dual_act_reg  <= dual_act_next;
            dual_hdl_reg  <= dual_hdl_next;
            wait_tap_reg  <= wait_tap_next;
            root_hold_reg <= root_hold_next;
            tv_reg        <= tv_next;
        end
    end

    // Timestamps, meaningful only under their valid bits
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_t_reg <= first_t_next;
            dual_t_reg  <= dual_t_next;
            lastb_t_reg <= lastb_t_next;
        end
    end

    `TBGD_ASSERT_IMPL(a_dual_needs_press, dual_act_reg, pressed_reg != 2'b00,
        "dual press active with no button down")
    `TBGD_ASSERT_IMPL(a_handled_needs_dual, dual_hdl_reg, dual_act_reg,
        "dual press marked handled while not active")

endmodule

// ===== rtl/tbgd_queue.sv =====
// Short queue of command bundles between the front and back parts.
module tbgd_queue
    import tbgd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_bundle,
    input  logic    pop,
    output bundle_t head,
    output q_stat_t q_stat
);

`include "assert_macros.svh"

    bundle_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Store pushed bundles
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    `TBGD_ASSERT_IMPL(a_no_push_full, q_stat.full, !push, "push into a full queue")
    `TBGD_ASSERT_IMPL(a_no_pop_empty, q_stat.empty, !pop, "pop from an empty queue")

endmodule

// ===== rtl/tbgd_back.sv =====
// Back part: sends the commands of each queued bundle one item at a time.
module tbgd_back
    import tbgd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bundle_t           head,
    input  q_stat_t           q_stat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CMD_W-1:0]  out_cmd,
    output logic              out_last
);

`include "assert_macros.svh"

    logic [CNT_W-1:0] idx_reg;

    assign out_valid = !q_stat.empty;
    assign out_cmd   = head.cmd[idx_reg];
    assign out_last  = (idx_reg == (head.cnt - CNT_W'(1)));
    assign pop       = out_valid && out_ready && out_last;

    // Step through the head bundle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            idx_reg <= out_last ? '0 : idx_reg + CNT_W'(1);
        end
    end

    `TBGD_ASSERT_IMPL(a_idx_in_bundle, out_valid, idx_reg < head.cnt,
        "command index beyond the head bundle")

endmodule

// ===== bench/tb_two_button_gesture_decoder_top.sv =====
// Self-checking bench for the two-button gesture decoder: event streams against a predictor.
`timescale 1ns / 1ps

module tb_two_button_gesture_decoder_top;
    import tbgd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LEN    = 60;
    localparam int MAX_REPORTS  = 20;
    localparam logic [ACT_W-1:0] ACT_FIRST_UNUSED = 3'd5;
    localparam logic [IDX_W-1:0] REG_UNUSED       = 3'd5;
    localparam logic [CFG_W-1:0] WINDOW_MAX       = CFG_W'(10000000);

    typedef struct {
        cmd_t cmd;
        logic tail;
    } cmd_exp_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TIME_W-1:0]     s_axis_tdata = '0;   // [31:0] time_us
    logic [ACT_W-1:0]      s_axis_tuser = '0;   // [2:0] action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [3:0] command
    logic                  m_axis_tlast;

    // Mirror of the decoder's configuration
    logic [CFG_W-1:0] win_dual, hold_long, press_short, win_tap;
    logic             mode_at_start;

    // Mirror of the decoder's gesture state
    logic        mode_now;
    logic [1:0]  btn_down, btn_held, btn_sent;
    logic        dual_on, dual_done, tap_wait, root_held;
    logic [31:0] t_first, t_dual, t_brel;
    logic [2:0]  t_ok;

    cmd_t     burst [MAX_RES];
    int       burst_n;
    cmd_exp_t cmd_expected [$];
    cmd_exp_t cmd_head;

    logic [31:0] clock_us = '0;
    logic        busy_stretch = 1'b0;
    int          stall_req_cnt = 0;
    int          stall_ack_cnt = 0;
    int          stall_left = 0;
    int          cycle_cnt = 0;
    int          err_cnt = 0;
    int          events_sent = 0;
    int          ignored_cnt = 0;
    int          cmds_checked = 0;
    int          cfg_writes = 0;
    int          mode_flips = 0;

    two_button_gesture_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] span(input logic [31:0] then_t, input logic [31:0] now_t);
        return now_t - then_t;
    endfunction

    function void add_cmd(input cmd_t c);
        if (burst_n < MAX_RES)
        begin
            burst[burst_n] = c;
            burst_n++;
        end
    endfunction

    function void model_reset();
        win_dual      = DPW_RST;
        hold_long     = LHM_RST;
        press_short   = SPM_RST;
        win_tap       = DTW_RST;
        mode_at_start = START_MODE_RST;
        mode_now      = START_MODE_RST;
        btn_down  = '0;
        btn_held  = '0;
        btn_sent  = '0;
        dual_on   = 1'b0;
        dual_done = 1'b0;
        tap_wait  = 1'b0;
        root_held = 1'b0;
        t_first   = '0;
        t_dual    = '0;
        t_brel    = '0;
        t_ok      = '0;
    endfunction

    function void model_config(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        case (idx)
            REG_DPW: win_dual = val;
            REG_LHM: hold_long = val;
            REG_SPM: press_short = val;
            REG_DTW: win_tap = val;
            REG_START_MODE:
            begin
                mode_at_start = val[0];
                mode_now      = val[0];
            end
            default: ;
        endcase
    endfunction

    function void drop_singles();
        btn_held = '0;
        btn_sent = '0;
    endfunction

    function void mark_first(input logic [31:0] now_t);
        t_first = now_t;
        t_ok[TV_FIRST] = 1'b1;
    endfunction

    // Change mode, clearing single and tap state
    function void switch_mode(input logic m);
        if (m != mode_now)
        begin
            drop_singles();
            tap_wait  = 1'b0;
            root_held = 1'b0;
            t_brel    = '0;
            t_ok[TV_LASTB] = 1'b0;
            mode_now  = m;
            mode_flips++;
            add_cmd(m ? CMD_ENTER_M1 : CMD_ENTER_M0);
        end
    endfunction

    // Enter a dual press, reverting optimistic single actions in sequencer mode
    function void start_dual(input logic [31:0] now_t);
        if (dual_on)
            return;
        if (mode_now && (btn_sent & BTN_A) != 0)
        begin
            add_cmd(CMD_A_TOGGLE);
            btn_sent &= ~BTN_A;
        end
        if (mode_now && (btn_down & BTN_B) != 0)
        begin
            if (root_held)
            begin
                add_cmd(CMD_UNARM);
                root_held = 1'b0;
            end
            else
                add_cmd(CMD_B_REL_M1);
            tap_wait = 1'b0;
        end
        drop_singles();
        dual_on   = 1'b1;
        dual_done = 1'b0;
        t_dual    = now_t;
        t_ok[TV_DUAL] = 1'b1;
    endfunction

    function void model_press(input logic [1:0] b, input logic [31:0] now_t);
        logic [1:0] other;
        other = b ^ 2'b11;
        btn_down |= b;
        if ((btn_down & other) == 0)
        begin
            if (mode_now)
            begin
                if (b == BTN_A)
                begin
                    add_cmd(CMD_A_TOGGLE);
                    btn_sent |= BTN_A;
                    btn_held &= ~BTN_A;
                    mark_first(now_t);
                    return;
                end
                // Second tap on B arms root edit
                if (tap_wait && t_ok[TV_LASTB] && span(t_brel, now_t) <= win_tap)
                begin
                    tap_wait  = 1'b0;
                    root_held = 1'b1;
                    add_cmd(CMD_ARM);
                    btn_held &= ~BTN_B;
                    btn_sent &= ~BTN_B;
                    mark_first(now_t);
                    return;
                end
                root_held = 1'b0;
                tap_wait  = 1'b1;
                add_cmd(CMD_B_PRESS_M1);
            end
            mark_first(now_t);
            btn_held |= b;
            return;
        end
        if (!t_ok[TV_FIRST])
            mark_first(now_t);
        if (span(t_first, now_t) <= win_dual)
        begin
            start_dual(now_t);
            drop_singles();
            return;
        end
        btn_held |= b;
    endfunction

    function void model_release(input logic [1:0] b, input logic [31:0] now_t);
        logic [31:0] held_for;
        btn_down &= ~b;
        if (!dual_on)
        begin
            if (mode_now)
            begin
                if (b == BTN_B)
                begin
                    held_for = t_ok[TV_FIRST] ? span(t_first, now_t) : 32'd0;
                    if (root_held)
                    begin
                        add_cmd(CMD_UNARM);
                        root_held = 1'b0;
                        tap_wait  = 1'b0;
                    end
                    else
                    begin
                        add_cmd(CMD_B_REL_M1);
                        tap_wait = (held_for <= press_short);
                    end
                    t_brel = now_t;
                    t_ok[TV_LASTB] = 1'b1;
                end
                btn_held &= ~b;
                btn_sent &= ~b;
            end
            else
            begin
                // Flush a held-back press before its release
                if ((btn_held & b) != 0 && (btn_sent & b) == 0)
                begin
                    add_cmd(b == BTN_A ? CMD_A_PRESS_M0 : CMD_B_PRESS_M0);
                    btn_sent |= b;
                    btn_held &= ~b;
                end
                if ((btn_sent & b) != 0)
                begin
                    add_cmd(b == BTN_A ? CMD_A_REL_M0 : CMD_B_REL_M0);
                    btn_sent &= ~b;
                end
            end
        end
        // Both buttons up: close any dual press and clear timing
        if (btn_down == 0)
        begin
            if (dual_on && !dual_done && t_ok[TV_DUAL] && span(t_dual, now_t) <= press_short)
            begin
                if (!mode_now)
                    add_cmd(CMD_PANIC);
            end
            dual_on   = 1'b0;
            dual_done = 1'b0;
            t_first   = '0;
            t_dual    = '0;
            t_ok[TV_FIRST] = 1'b0;
            t_ok[TV_DUAL]  = 1'b0;
            root_held = 1'b0;
            drop_singles();
        end
    endfunction

    function void model_tick(input logic [31:0] now_t);
        if (dual_on && !dual_done && t_ok[TV_DUAL] && span(t_dual, now_t) >= hold_long)
        begin
            switch_mode(~mode_now);
            dual_done = 1'b1;
        end
        if (mode_now || dual_on || !t_ok[TV_FIRST])
            return;
        if (span(t_first, now_t) < win_dual)
            return;
        if ((btn_held & BTN_A) != 0 && (btn_sent & BTN_A) == 0)
        begin
            add_cmd(CMD_A_PRESS_M0);
            btn_sent |= BTN_A;
            btn_held &= ~BTN_A;
        end
        if ((btn_held & BTN_B) != 0 && (btn_sent & BTN_B) == 0)
        begin
            add_cmd(CMD_B_PRESS_M0);
            btn_sent |= BTN_B;
            btn_held &= ~BTN_B;
        end
    endfunction

    // Work out the commands of one accepted item and queue them
    function void predict_commands(input logic [ACT_W-1:0] act, input logic [31:0] now_t);
        cmd_exp_t e;
        burst_n = 0;
        case (act)
            ACT_TICK:    model_tick(now_t);
            ACT_A_PRESS: model_press(BTN_A, now_t);
            ACT_A_REL:   model_release(BTN_A, now_t);
            ACT_B_PRESS: model_press(BTN_B, now_t);
            ACT_B_REL:   model_release(BTN_B, now_t);
            default: ;
        endcase
        for (int i = 0; i < burst_n; i++)
        begin
            e.cmd  = burst[i];
            e.tail = (i == burst_n - 1);
            cmd_expected.push_back(e);
        end
    endfunction

    // ---------------------------------------------------------------- checker

    // Compare each accepted command with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (cmd_expected.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected command: expected none, got tdata %0d tlast %0b",
                             $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                cmd_head = cmd_expected.pop_front();
                cmds_checked++;
                if (m_axis_tdata !== OUT_DATA_W'(cmd_head.cmd))
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: command mismatch: expected %0d, got %0d",
                                 $time, cmd_head.cmd, m_axis_tdata);
                end
                if (m_axis_tlast !== cmd_head.tail)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: tlast mismatch: expected %0b, got %0b",
                                 $time, cmd_head.tail, m_axis_tlast);
                end
            end
        end
    end

    // Receiver: random idling, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_ack_cnt != stall_req_cnt)
            begin
                stall_ack_cnt++;
                stall_left = STALL_LEN;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= busy_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Abort a hung run
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("%0t: timeout after %0d cycles, %0d commands still expected",
                 $time, cycle_cnt, cmd_expected.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    // Offer one item and hold it until accepted
    task automatic send_event(input logic [ACT_W-1:0] act, input logic [31:0] stamp);
        if (!busy_stretch && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= stamp;
        do @(posedge clk); while (!s_axis_tready);
        predict_commands(act, stamp);
        if (act > ACT_B_REL)
            ignored_cnt++;
        else
            events_sent++;
    endtask

    task automatic send_at(input logic [ACT_W-1:0] act, input logic [31:0] stamp);
        clock_us = stamp;
        send_event(act, stamp);
    endtask

    task automatic send_after(input logic [ACT_W-1:0] act, input logic [31:0] delta);
        clock_us = clock_us + delta;
        send_event(act, clock_us);
    endtask

    // Drop valid, wait for all commands, then let the pipeline drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (cmd_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_config(idx, val);
        cfg_writes++;
        @(posedge clk);
    endtask

    // Time steps, some landing on and around the configured thresholds
    function automatic logic [31:0] pick_delta();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 200);
            2:       return 32'(win_dual) + $urandom_range(0, 2) - 32'd1;
            3:       return 32'(press_short) + $urandom_range(0, 2) - 32'd1;
            4:       return 32'(hold_long) + $urandom_range(0, 2) - 32'd1;
            5:       return 32'(win_tap) + $urandom_range(0, 2) - 32'd1;
            6, 7:    return $urandom_range(0, 400000);
            8:       return $urandom_range(0, 3000000);
            default: return $urandom();
        endcase
    endfunction

    // Mostly well-formed gestures with random timing, some noise
    task automatic random_gestures(input int n_items);
        int   base;
        logic use_a;
        logic a_first;
        base = events_sent;
        while (events_sent - base < n_items)
        begin
            use_a = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                // Single press, a few ticks, release
                0, 1, 2:
                begin
                    send_after(use_a ? ACT_A_PRESS : ACT_B_PRESS, pick_delta());
                    repeat ($urandom_range(0, 2)) send_after(ACT_TICK, pick_delta());
                    send_after(use_a ? ACT_A_REL : ACT_B_REL, pick_delta());
                    if ($urandom_range(0, 1))
                        send_after(ACT_TICK, pick_delta());
                end
                // Dual press, ticks, releases in either order
                3, 4, 5:
                begin
                    send_after(use_a ? ACT_A_PRESS : ACT_B_PRESS, pick_delta());
                    send_after(use_a ? ACT_B_PRESS : ACT_A_PRESS,
                               $urandom_range(0, 3) == 0 ? pick_delta()
                                                         : $urandom_range(0, win_dual));
                    repeat ($urandom_range(0, 3)) send_after(ACT_TICK, pick_delta());
                    a_first = 1'($urandom_range(0, 1));
                    send_after(a_first ? ACT_A_REL : ACT_B_REL, pick_delta());
                    send_after(a_first ? ACT_B_REL : ACT_A_REL, $urandom_range(0, 1000));
                end
                // Double tap on B, then hold and release
                6, 7:
                begin
                    send_after(ACT_B_PRESS, pick_delta());
                    send_after(ACT_B_REL, $urandom_range(0, 1) ? $urandom_range(0, press_short)
                                                               : pick_delta());
                    send_after(ACT_B_PRESS, $urandom_range(0, 1) ? $urandom_range(0, win_tap)
                                                                 : pick_delta());
                    repeat ($urandom_range(0, 2)) send_after(ACT_TICK, pick_delta());
                    send_after(ACT_B_REL, pick_delta());
                end
                // Noise: any code, any timestamp
                default:
                    repeat ($urandom_range(1, 3))
                        send_event(ACT_W'($urandom_range(0, 2**ACT_W - 1)), $urandom());
            endcase
        end
    endtask

    // ---------------------------------------------------------------- tests

    // Mode 0: presses held back until the window passes or the release comes
    task automatic test_held_singles();
        send_at(ACT_A_PRESS, 32'd0);
        send_at(ACT_TICK, 32'd49999);
        send_at(ACT_TICK, 32'd50000);
        send_at(ACT_A_REL, 32'd60000);
        send_at(ACT_B_PRESS, 32'd100000);
        send_at(ACT_B_REL, 32'd100010);
        // Unknown codes change nothing
        for (int k = ACT_FIRST_UNUSED; k < 2**ACT_W; k++)
            send_at(ACT_W'(k), 32'hFFFF_FFFF);
        send_at(ACT_TICK, 32'hFFFF_FFFF);
    endtask

    // Short dual press gives panic; a redundant release after it
    task automatic test_dual_panic();
        send_at(ACT_A_PRESS, 32'd200000);
        send_at(ACT_B_PRESS, 32'd200100);
        send_at(ACT_A_REL, 32'd200150);
        send_at(ACT_B_REL, 32'd200200);
        send_at(ACT_A_REL, 32'd200300);
    endtask

    // Long dual hold toggles into sequencer mode, one microsecond of hold short of it first
    task automatic test_mode_toggle();
        send_at(ACT_B_PRESS, 32'd1000);
        send_at(ACT_A_PRESS, 32'd1010);
        send_at(ACT_TICK, 32'd1001009);
        send_at(ACT_TICK, 32'd1001010);
        send_at(ACT_B_REL, 32'd1001100);
        send_at(ACT_A_REL, 32'd1001200);
    endtask

    // Sequencer mode: toggle, redundant press, double tap across the timestamp wrap,
    // dual press reverting single actions, backwards time on a tick
    task automatic test_sequencer_gestures();
        send_at(ACT_A_PRESS, 32'd2000000);
        send_at(ACT_A_PRESS, 32'd2000001);
        send_at(ACT_A_REL, 32'd2000100);
        send_at(ACT_B_PRESS, 32'hFFFF_FF00);
        send_at(ACT_B_REL, 32'hFFFF_FF10);
        send_at(ACT_B_PRESS, 32'h0000_0010);
        send_at(ACT_B_REL, 32'h0000_0020);
        send_at(ACT_A_PRESS, 32'h0000_1000);
        send_at(ACT_B_PRESS, 32'h0000_1005);
        send_at(ACT_TICK, 32'h0000_1004);
        send_at(ACT_A_REL, 32'h0000_1100);
        send_at(ACT_B_REL, 32'h0000_1200);
    endtask

    task automatic test_random_defaults();
        random_gestures(25);
        busy_stretch = 1'b1;
        random_gestures(15);
        busy_stretch = 1'b0;
    endtask

    // All windows at zero and at WINDOW_MAX, both start modes, an unused index
    task automatic test_register_extremes();
        settle();
        write_reg(REG_DPW, '0);
        write_reg(REG_LHM, '0);
        write_reg(REG_SPM, '0);
        write_reg(REG_DTW, '0);
        write_reg(REG_START_MODE, CFG_W'(1));
        write_reg(REG_UNUSED, WINDOW_MAX);
        random_gestures(20);
        settle();
        write_reg(REG_DPW, WINDOW_MAX);
        write_reg(REG_LHM, WINDOW_MAX);
        write_reg(REG_SPM, WINDOW_MAX);
        write_reg(REG_DTW, WINDOW_MAX);
        write_reg(REG_START_MODE, '0);
        random_gestures(20);
    endtask

    task automatic test_random_registers();
        settle();
        write_reg(REG_DPW, CFG_W'($urandom_range(0, 200000)));
        write_reg(REG_LHM, CFG_W'($urandom_range(0, WINDOW_MAX)));
        write_reg(REG_SPM, CFG_W'($urandom_range(0, 600000)));
        write_reg(REG_DTW, CFG_W'($urandom_range(0, 600000)));
        write_reg(REG_START_MODE, CFG_W'($urandom_range(0, 1)));
        random_gestures(20);
    endtask

    // Receiver holds off while A toggles keep arriving, so the queue fills
    task automatic test_output_backpressure();
        settle();
        write_reg(REG_START_MODE, CFG_W'(1));
        send_after(ACT_A_REL, 32'd10);
        send_after(ACT_B_REL, 32'd10);
        stall_req_cnt++;
        repeat (6)
        begin
            send_after(ACT_A_PRESS, $urandom_range(1, 100));
            send_after(ACT_A_REL, $urandom_range(1, 100));
        end
    endtask

    initial
    begin
        model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_held_singles();
        test_dual_panic();
        test_mode_toggle();
        test_sequencer_gestures();
        test_random_defaults();
        test_register_extremes();
        test_random_registers();
        test_output_backpressure();
        settle();

        $display("Covered %0d button and tick events, %0d unknown codes, %0d register writes,",
                 events_sent, ignored_cnt, cfg_writes);
        $display("%0d commands checked, %0d mode changes predicted, %0d mismatches",
                 cmds_checked, mode_flips, err_cnt);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tbgd_pkg.sv
rtl/tbgd_front.sv
rtl/tbgd_queue.sv
rtl/tbgd_back.sv
rtl/two_button_gesture_decoder_top.sv
bench/tb_two_button_gesture_decoder_top.sv
